>>> design/fsa_pkg.sv
// Package for the flow statistics accumulator: transaction types, row layout
// and the constants shared by the controller and the datapath.
// No dependencies.
package fsa_pkg;

	localparam int unsigned ROW_WORDS = 39;
	localparam int unsigned ROW_BITS  = ROW_WORDS * 64;
	localparam logic [63:0] MIN_START = 64'd2147483647;
	localparam logic [7:0]  PSH_MASK  = 8'b0000_1000;
	localparam logic [7:0]  URG_MASK  = 8'b0010_0000;

	// Word positions within a row.
	localparam int unsigned W_FWD_CNT    = 0;
	localparam int unsigned W_BWD_CNT    = 1;
	localparam int unsigned W_MIN_B      = 2;
	localparam int unsigned W_MAX_B      = 3;
	localparam int unsigned W_TTL_B      = 4;
	localparam int unsigned W_FWD_B      = 5;
	localparam int unsigned W_BWD_B      = 8;
	localparam int unsigned W_PREV_TS    = 11;
	localparam int unsigned W_MIN_IAT    = 12;
	localparam int unsigned W_MAX_IAT    = 13;
	localparam int unsigned W_TTL_IAT    = 14;
	localparam int unsigned W_FWD_IAT    = 15;
	localparam int unsigned W_BWD_IAT    = 18;
	localparam int unsigned W_FWD_PSH    = 21;
	localparam int unsigned W_FWD_URG    = 22;
	localparam int unsigned W_BWD_PSH    = 23;
	localparam int unsigned W_BWD_URG    = 24;
	localparam int unsigned W_FLAG0      = 25;
	localparam int unsigned W_FWD_SEG    = 33;
	localparam int unsigned W_BWD_SEG    = 34;
	localparam int unsigned W_FWD_DATA   = 35;
	localparam int unsigned W_BWD_DATA   = 36;
	localparam int unsigned W_FWD_SEGMIN = 37;
	localparam int unsigned W_BWD_SEGMIN = 38;

	// Flag bit counted by each flag counter: FIN SYN RST PSH ACK URG CWR ECE.
	localparam logic [7:0][2:0] FLAG_BIT = {3'd6, 3'd7, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_READ   = 1'b1;

	typedef logic [ROW_WORDS-1:0][63:0] row_t;

	typedef struct packed {
		logic        action;
		logic [9:0]  flow_slot;
		logic        first_packet;
		logic        backward_dir;
		logic [15:0] payload_bytes;
		logic [7:0]  flag_bits;
		logic [63:0] arrival_us;
		logic [5:0]  stat_select;
	} in_t;

	typedef struct packed {
		logic [9:0]  read_slot;
		logic [63:0] stat_value;
	} out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic rd_en;
		logic calc;
		logic wr_en;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_read;
		logic in_range;
	} sts_t;

	// Row contents of a new flow.
	function automatic row_t init_row();
		row_t r;
		r = '0;
		r[W_MIN_B]      = MIN_START;
		r[W_FWD_B]      = MIN_START;
		r[W_BWD_B]      = MIN_START;
		r[W_MIN_IAT]    = MIN_START;
		r[W_FWD_IAT]    = MIN_START;
		r[W_BWD_IAT]    = MIN_START;
		r[W_FWD_SEGMIN] = MIN_START;
		r[W_BWD_SEGMIN] = MIN_START;
		return r;
	endfunction

endpackage

>>> design/fsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fsa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> design/fsa_ctrl.sv
// Controller for the flow statistics accumulator: sequences read, compute
// and, for an update, write-back of one row per transaction. Depends on fsa_pkg.
module fsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  fsa_pkg::sts_t sts,
	output fsa_pkg::cmd_t cmd
);
	import fsa_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_WRITE} state_t;
	state_t state_q;

	// Command decode from the current state.
	always_comb begin
		cmd.load  = (state_q == S_IDLE) && start;
		cmd.rd_en = (state_q == S_READ);
		cmd.calc  = (state_q == S_CALC);
		cmd.wr_en = (state_q == S_WRITE) && sts.in_range;
	end

	// State register and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_READ;
						busy    <= 1'b1;
					end
				end
				S_READ: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (sts.is_read) begin
						state_q <= S_IDLE;
						busy    <= 1'b0;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy    <= 1'b0;
				end
			endcase
		end
	end
endmodule

>>> design/fsa_dp.sv
// Datapath for the flow statistics accumulator: transaction register, row
// memory, inter-arrival register, row update and word select.
// Depends on fsa_pkg and fsa_ram.
module fsa_dp #(
	parameter int unsigned FLOW_SLOTS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fsa_pkg::in_t  item,
	input  fsa_pkg::cmd_t cmd,
	output fsa_pkg::sts_t sts,
	output logic          result_valid,
	output fsa_pkg::out_t result
);
	import fsa_pkg::*;

	localparam int unsigned AW = $clog2(FLOW_SLOTS > 1 ? FLOW_SLOTS : 2);

	in_t         item_q;
	row_t        rdata;
	row_t        base;
	row_t        nr;
	logic [63:0] iat_q;
	logic [16:0] slot_ext;
	logic [AW-1:0] addr;
	logic        bwd;
	logic [63:0] bytes;
	logic [63:0] fmin;

	// Transaction register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	assign slot_ext     = 17'(item_q.flow_slot);
	assign addr         = slot_ext[AW-1:0];
	assign sts.in_range = (slot_ext < 17'(FLOW_SLOTS));
	assign sts.is_read  = (item_q.action == ACT_READ);

	fsa_ram #(.WIDTH(ROW_BITS), .DEPTH(FLOW_SLOTS)) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (addr),
		.wdata (nr),
		.re    (cmd.rd_en),
		.raddr (addr),
		.rdata (rdata)
	);

	// Starting row: a new flow begins from the initial row.
	assign base = item_q.first_packet ? init_row() : rdata;

	// Inter-arrival time and read result.
	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			iat_q <= item_q.arrival_us - base[W_PREV_TS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.calc && sts.is_read;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			result.read_slot  <= item_q.flow_slot;
			result.stat_value <= '0;
			if (sts.in_range && item_q.stat_select < 6'(ROW_WORDS)) begin
				result.stat_value <= rdata[item_q.stat_select];
			end
		end
	end

	assign bwd   = item_q.backward_dir;
	assign bytes = 64'(item_q.payload_bytes);
	assign fmin  = bwd ? base[W_BWD_B] : base[W_FWD_B];

	// Row update: each word takes at most one add or compare.
	always_comb begin
		nr = base;
		nr[W_TTL_B] = base[W_TTL_B] + bytes;
		if (bytes < base[W_MIN_B]) nr[W_MIN_B] = bytes;
		if (bytes > base[W_MAX_B]) nr[W_MAX_B] = bytes;
		for (int i = 0; i < 8; i++) begin
			if (item_q.flag_bits[FLAG_BIT[i]]) nr[W_FLAG0+i] = base[W_FLAG0+i] + 64'd1;
		end
		nr[W_PREV_TS] = item_q.arrival_us;
		nr[W_TTL_IAT] = base[W_TTL_IAT] + iat_q;
		if (iat_q < base[W_MIN_IAT]) nr[W_MIN_IAT] = iat_q;
		if (iat_q > base[W_MAX_IAT]) nr[W_MAX_IAT] = iat_q;
		if (!bwd) begin
			nr[W_FWD_CNT] = base[W_FWD_CNT] + 64'd1;
			nr[W_FWD_B+2] = base[W_FWD_B+2] + bytes;
			if (bytes < fmin) nr[W_FWD_SEGMIN] = bytes;
			if (bytes < base[W_FWD_B]) nr[W_FWD_B] = bytes;
			if (bytes > base[W_FWD_B+1]) nr[W_FWD_B+1] = bytes;
			nr[W_FWD_IAT+2] = base[W_FWD_IAT+2] + iat_q;
			if (iat_q < base[W_FWD_IAT]) nr[W_FWD_IAT] = iat_q;
			if (iat_q > base[W_FWD_IAT+1]) nr[W_FWD_IAT+1] = iat_q;
			if ((item_q.flag_bits & PSH_MASK) != '0) nr[W_FWD_PSH] = base[W_FWD_PSH] + 64'd1;
			if ((item_q.flag_bits & URG_MASK) != '0) nr[W_FWD_URG] = base[W_FWD_URG] + 64'd1;
			nr[W_FWD_SEG] = base[W_FWD_SEG] + bytes;
			if (bytes != '0) nr[W_FWD_DATA] = base[W_FWD_DATA] + 64'd1;
		end else begin
			nr[W_BWD_CNT] = base[W_BWD_CNT] + 64'd1;
			nr[W_BWD_B+2] = base[W_BWD_B+2] + bytes;
			if (bytes < fmin) nr[W_BWD_SEGMIN] = bytes;
			if (bytes < base[W_BWD_B]) nr[W_BWD_B] = bytes;
			if (bytes > base[W_BWD_B+1]) nr[W_BWD_B+1] = bytes;
			nr[W_BWD_IAT+2] = base[W_BWD_IAT+2] + iat_q;
			if (iat_q < base[W_BWD_IAT]) nr[W_BWD_IAT] = iat_q;
			if (iat_q > base[W_BWD_IAT+1]) nr[W_BWD_IAT+1] = iat_q;
			if ((item_q.flag_bits & PSH_MASK) != '0) nr[W_BWD_PSH] = base[W_BWD_PSH] + 64'd1;
			if ((item_q.flag_bits & URG_MASK) != '0) nr[W_BWD_URG] = base[W_BWD_URG] + 64'd1;
			nr[W_BWD_SEG] = base[W_BWD_SEG] + bytes;
			if (bytes != '0) nr[W_BWD_DATA] = base[W_BWD_DATA] + 64'd1;
		end
	end
endmodule

>>> design/flow_statistics_accumulator.sv
// Flow statistics accumulator, top level. Depends on fsa_pkg, fsa_ctrl, fsa_dp.
// An update runs accept, row read, inter-arrival, write-back; a read runs accept,
// row read, result; the result strobes for one cycle right after, while the next
// transaction may already be accepted. Transactions are taken one at a time. Reset
// clears the controller and the result strobe; the table is undefined until a
// first packet initializes a row. The receiver cannot stall results.
module flow_statistics_accumulator #(
	parameter int unsigned FLOW_SLOTS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  fsa_pkg::in_t  item,
	output logic          result_valid,
	output fsa_pkg::out_t result
);
	import fsa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	fsa_dp #(.FLOW_SLOTS(FLOW_SLOTS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result       (result)
	);
endmodule
